// ===== sv/single_float_convert_unit_assert.svh =====
// Assertion macros shared by the conversion unit.
// Both macros sample on the rising edge of clk and are disabled while rst is high.
`ifndef SINGLE_FLOAT_CONVERT_UNIT_ASSERT_SVH
`define SINGLE_FLOAT_CONVERT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFCU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sfcu_pkg.sv =====
`default_nettype none

package sfcu_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    MODE_I2F = 2'd0,
    MODE_F2I = 2'd1,
    MODE_DBL = 2'd2
  } mode_t;

  localparam logic [7:0] EXP_BIAS = 8'd127;
  localparam logic [7:0] EXP_MAX  = 8'hFF;
  localparam logic [7:0] EXP_TOP  = 8'hFE;
  localparam logic [7:0] INT_EXP_LIMIT = 8'd31;
  localparam word_t      INT_OVF  = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== sv/sfcu_i2f.sv =====
`default_nettype none

module sfcu_i2f (
  input  sfcu_pkg::word_t operand,
  output sfcu_pkg::word_t result
);
  import sfcu_pkg::*;

  word_t      mag;
  word_t      norm;
  logic [4:0] msb;
  logic [7:0] expo;
  logic       up;

  always_comb begin
    mag = operand[31] ? (~operand + 32'd1) : operand;
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        msb = 5'(i);
      end
    end
    norm = mag << (5'd31 - msb);
    // Round to nearest, ties to even; the guard bit sits just below the fraction.
    up   = norm[7] & ((|norm[6:0]) | norm[8]);
    expo = {3'b000, msb} + EXP_BIAS;
    if (operand == 32'd0) begin
      result = 32'd0;
    end else begin
      result = {operand[31], expo, norm[30:8]} + {31'd0, up};
    end
  end

endmodule

`default_nettype wire

// ===== sv/sfcu_f2i.sv =====
`default_nettype none

module sfcu_f2i (
  input  sfcu_pkg::word_t operand,
  output sfcu_pkg::word_t result
);
  import sfcu_pkg::*;

  logic [7:0]  ex;
  logic [7:0]  unb;
  logic [23:0] mant;
  logic [54:0] wide;
  word_t       mag;

  always_comb begin
    ex   = operand[30:23];
    unb  = ex - EXP_BIAS;
    mant = {1'b1, operand[22:0]};
    wide = {31'd0, mant} << unb[4:0];
    mag  = wide[54:23];
    priority if (ex == EXP_MAX) begin
      result = INT_OVF;
    end else if (ex < EXP_BIAS) begin
      result = 32'd0;
    end else if (unb >= INT_EXP_LIMIT) begin
      result = INT_OVF;
    end else begin
      result = operand[31] ? (~mag + 32'd1) : mag;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sfcu_dbl.sv =====
`default_nettype none

module sfcu_dbl (
  input  sfcu_pkg::word_t operand,
  output sfcu_pkg::word_t result
);
  import sfcu_pkg::*;

  logic [7:0] ex;

  always_comb begin
    ex = operand[30:23];
    priority if (ex == 8'd0) begin
      result = {operand[31], operand[29:0], 1'b0};
    end else if (ex == EXP_MAX) begin
      result = operand;
    end else if (ex == EXP_TOP) begin
      result = {operand[31], EXP_MAX, 23'd0};
    end else begin
      result = operand + 32'h0080_0000;
    end
  end

endmodule

`default_nettype wire

// ===== sv/single_float_convert_unit.sv =====
// An accepted item is captured in the input register, converted, and then captured in the
// result register when that register can advance; m_axis_tvalid then marks it valid.
// Throughput: one item per cycle while the output is not stalled; one input register
// and one result register, with a single pass of combinational logic between them.
// Reset (rst, synchronous, active high) clears both valid flags only.
`default_nettype none

`include "single_float_convert_unit_assert.svh"

module single_float_convert_unit (
  input  wire             clk,
  input  wire             rst,
  input  wire             s_axis_tvalid,
  output logic            s_axis_tready,
  input  sfcu_pkg::word_t s_axis_tdata,  // [31:0] operand
  input  wire [1:0]       s_axis_tuser,  // [1:0] mode
  output logic            m_axis_tvalid,
  input  wire             m_axis_tready,
  output sfcu_pkg::word_t m_axis_tdata   // [31:0] result
);
  import sfcu_pkg::*;

  logic  s0_valid;
  mode_t s0_mode;
  word_t s0_operand;
  logic  advance;
  word_t i2f_result;
  word_t f2i_result;
  word_t dbl_result;
  word_t result_next;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s0_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s0_mode    <= mode_t'(s_axis_tuser);
      s0_operand <= s_axis_tdata;
    end
  end

  sfcu_i2f u_i2f (.operand(s0_operand), .result(i2f_result));
  sfcu_f2i u_f2i (.operand(s0_operand), .result(f2i_result));
  sfcu_dbl u_dbl (.operand(s0_operand), .result(dbl_result));

  always_comb begin
    unique case (s0_mode)
      MODE_I2F: result_next = i2f_result;
      MODE_F2I: result_next = f2i_result;
      MODE_DBL: result_next = dbl_result;
      default:  result_next = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s0_valid) begin
      m_axis_tdata <= result_next;
    end
  end

  `SFCU_ASSERT_NOW(a_blocked_when_full, s0_valid && !advance, !s_axis_tready,
    "input taken while the input register is held")
  `SFCU_ASSERT_NOW(a_ready_when_empty, !s0_valid, s_axis_tready,
    "empty input register refuses an item")
  `SFCU_ASSERT_NEXT(a_item_moves, s0_valid && advance, m_axis_tvalid,
    "item lost between the input and result registers")
  `SFCU_ASSERT_NEXT(a_nan_to_int,
    s0_valid && advance && s0_mode == MODE_F2I && s0_operand[30:23] == EXP_MAX,
    m_axis_tdata == INT_OVF,
    "NaN or infinity did not convert to the overflow pattern")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfcu_pkg::*;

  localparam word_t FRAC_MASK      = 32'h007F_FFFF;
  localparam word_t INT_MIN_SINGLE = 32'hCF00_0000;
  localparam int unsigned RANDOM_PER_PHASE = 407;
  localparam int unsigned PHASES = 4;
  localparam int unsigned SEND_IDLE_PCT [PHASES] = '{0, 49, 0, 25};
  localparam int unsigned RECV_STALL_PCT [PHASES] = '{0, 0, 49, 25};

  typedef struct packed {
    mode_t mode;
    word_t operand;
    logic  known;
    word_t result;
  } row_t;

  localparam int unsigned NUM_ROWS = 25;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{MODE_I2F, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_I2F, 32'h8000_0000, 1'b1, 32'hCF00_0000},
    '{MODE_I2F, 32'h0000_0001, 1'b1, 32'h3F80_0000},
    '{MODE_I2F, 32'hFFFF_FFFF, 1'b1, 32'hBF80_0000},
    '{MODE_I2F, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{MODE_I2F, 32'h0100_0003, 1'b0, 32'h0000_0000},
    '{MODE_I2F, 32'h0100_0001, 1'b0, 32'h0000_0000},
    '{MODE_I2F, 32'h00FF_FFFF, 1'b0, 32'h0000_0000},
    '{MODE_F2I, 32'h7F80_0000, 1'b1, 32'h8000_0000},
    '{MODE_F2I, 32'h7FC0_0000, 1'b1, 32'h8000_0000},
    '{MODE_F2I, 32'hFF80_0000, 1'b1, 32'h8000_0000},
    '{MODE_F2I, 32'h4F00_0000, 1'b1, 32'h8000_0000},
    '{MODE_F2I, 32'hCF00_0000, 1'b1, 32'h8000_0000},
    '{MODE_F2I, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_F2I, 32'h0000_0001, 1'b1, 32'h0000_0000},
    '{MODE_F2I, 32'h3F7F_FFFF, 1'b1, 32'h0000_0000},
    '{MODE_F2I, 32'h3F80_0000, 1'b1, 32'h0000_0001},
    '{MODE_F2I, 32'hBFC0_0000, 1'b0, 32'h0000_0000},
    '{MODE_F2I, 32'h4EFF_FFFF, 1'b0, 32'h0000_0000},
    '{MODE_DBL, 32'h0000_0001, 1'b1, 32'h0000_0002},
    '{MODE_DBL, 32'h8040_0000, 1'b0, 32'h0000_0000},
    '{MODE_DBL, 32'h7F00_0000, 1'b1, 32'h7F80_0000},
    '{MODE_DBL, 32'hFF7F_FFFF, 1'b1, 32'hFF80_0000},
    '{MODE_DBL, 32'h7FC0_0001, 1'b1, 32'h7FC0_0001},
    '{MODE_DBL, 32'hFF80_0000, 1'b1, 32'hFF80_0000}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  word_t      s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = MODE_I2F;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  word_t      m_axis_tdata;

  word_t       result_q[$];
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  single_float_convert_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic word_t int_to_single(input word_t x);
    word_t       mag;
    word_t       frac;
    word_t       rem;
    word_t       half;
    int unsigned msb;
    int unsigned sh;
    logic        up;
    if (x == '0) return '0;
    if (x == INT_OVF) return INT_MIN_SINGLE;
    mag = x[31] ? -x : x;
    msb = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) msb = i;
    up = 1'b0;
    if (msb <= 23) begin
      frac = (mag << (23 - msb)) & FRAC_MASK;
    end else begin
      sh = msb - 23;
      rem = mag & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      frac = (mag >> sh) & FRAC_MASK;
      up = (rem > half) || (rem == half && frac[0]);
    end
    return ({x[31], 31'd0} | (word_t'(msb + EXP_BIAS) << 23)) + frac + word_t'(up);
  endfunction

  function automatic word_t single_to_int(input word_t f);
    logic [7:0]  ex;
    int unsigned e;
    word_t       mant;
    word_t       mag;
    ex = f[30:23];
    if (ex == EXP_MAX) return INT_OVF;
    if (ex < EXP_BIAS) return '0;
    e = ex - EXP_BIAS;
    if (e >= INT_EXP_LIMIT) return INT_OVF;
    mant = {8'd0, 1'b1, f[22:0]};
    mag = (e <= 23) ? (mant >> (23 - e)) : (mant << (e - 23));
    return f[31] ? -mag : mag;
  endfunction

  function automatic word_t single_doubled(input word_t f);
    logic [7:0] ex;
    ex = f[30:23];
    if (ex == 8'd0) return {f[31], f[29:0], 1'b0};
    if (ex == EXP_MAX) return f;
    if (ex == EXP_TOP) return {f[31], EXP_MAX, 23'd0};
    return f + (32'd1 << 23);
  endfunction

  function automatic word_t convert_word(input mode_t mode, input word_t operand);
    case (mode)
      MODE_I2F: return int_to_single(operand);
      MODE_F2I: return single_to_int(operand);
      MODE_DBL: return single_doubled(operand);
      default:  return '0;
    endcase
  endfunction

  // Mixes plain random words with float patterns around the interesting
  // exponents, integers of every length, and words with rounding ties.
  function automatic word_t random_operand();
    word_t       v;
    logic [7:0]  ex;
    int unsigned k;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: ex = 8'd0;
          1: ex = EXP_TOP;
          2: ex = EXP_MAX;
          default: ex = 8'($urandom_range(120, 160));
        endcase
        v = {1'($urandom), ex, 23'($urandom)};
        if ($urandom_range(0, 3) == 0) v[22:0] = 23'($urandom_range(0, 1));
      end
      2: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        k = $urandom_range(1, 8);
        v = $urandom >> $urandom_range(0, 6);
        v = (v & ~((32'd1 << k) - 32'd1)) | (32'd1 << (k - 1));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < 10) $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  // The valid line is left high after an accepted item, so the next item
  // either lowers it while idling or replaces the data.
  task automatic send_item(input mode_t mode, input word_t operand, input logic known,
                           input word_t result);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= operand;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    result_q.push_back(known ? result : convert_word(mode, operand));
  endtask

  always @(posedge clk) begin : result_check
    word_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          flag_error($sformatf("unexpected item, result %h", m_axis_tdata));
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata !== want)
            flag_error($sformatf("result mismatch: expected %h, got %h", want, m_axis_tdata));
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].operand, DIRECTED_ROWS[i].known,
                DIRECTED_ROWS[i].result);
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = SEND_IDLE_PCT[p];
      recv_stall_pct = RECV_STALL_PCT[p];
      repeat (RANDOM_PER_PHASE)
        send_item(mode_t'($urandom_range(0, 2)), random_operand(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
